>>> rtl/dcrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA register port package
// Shared types, opcodes and command codes of the DMA controller register port.
// ----------------------------------------------------------------------------
package dcrp_pkg;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_REPORT = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      TGT_ADDR_A_LO  = 4'd0,
      TGT_ADDR_A_HI  = 4'd1,
      TGT_LEN_LO     = 4'd2,
      TGT_LEN_HI     = 4'd3,
      TGT_DISCARD    = 4'd4,
      TGT_MASK       = 4'd5,
      TGT_MATCH      = 4'd6,
      TGT_ADDR_B_LO  = 4'd7,
      TGT_ADDR_B_HI  = 4'd8,
      TGT_INT_CTRL   = 4'd9,
      TGT_INT_PULSE  = 4'd10,
      TGT_INT_VECTOR = 4'd11,
      TGT_READ_MASK  = 4'd12
   } target_type;

   localparam logic [7:0] CMD_DISABLE   = 8'h83;
   localparam logic [7:0] CMD_ENABLE    = 8'h87;
   localparam logic [7:0] CMD_CLR_FLAGS = 8'h8b;
   localparam logic [7:0] CMD_REINIT_RD = 8'ha7;
   localparam logic [7:0] CMD_INT_ON    = 8'hab;
   localparam logic [7:0] CMD_INT_OFF   = 8'haf;
   localparam logic [7:0] CMD_FORCE_RDY = 8'hb3;
   localparam logic [7:0] CMD_RD_MASK   = 8'hbb;
   localparam logic [7:0] CMD_RD_STATUS = 8'hbf;
   localparam logic [7:0] CMD_RESET     = 8'hc3;
   localparam logic [7:0] CMD_LOAD      = 8'hcf;
   localparam logic [7:0] CMD_CONTINUE  = 8'hd3;
   localparam logic [7:0] STATUS_BASE   = 8'hcc;
   localparam logic [7:0] STATUS_RESET  = 8'h38;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  data_byte;
      logic [15:0] report_byte_count;
      logic [15:0] report_pointer_a;
      logic [15:0] report_pointer_b;
      logic        report_match;
      logic        report_end;
      logic        report_stopped;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        transfer_enabled;
      logic        interrupt_enabled;
      logic [1:0]  command;
      logic [1:0]  mode;
      logic        direction_a_to_b;
      logic [15:0] pointer_a;
      logic [15:0] pointer_b;
      logic [15:0] block_length;
      logic [7:0]  port_a_setting;
      logic [7:0]  port_b_setting;
      logic [7:0]  match_byte;
   } rsp_type;

   function automatic logic [15:0] step_counter(input logic [15:0] c, input logic [7:0] s);
      logic [15:0] r;
      case (s[5:4])
         2'b00: r = c - 16'd1;
         2'b01: r = c + 16'd1;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/dcrp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA register port channel
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface dcrp_req_if;
   import dcrp_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dcrp_rsp_if;
   import dcrp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/dcrp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA register port core
// Register state and combinational decode of one bus access into one result.
// ----------------------------------------------------------------------------
module dcrp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  dcrp_pkg::req_type req,
   output dcrp_pkg::rsp_type rsp
);
   import dcrp_pkg::*;

   logic [7:0]  group_ff [7];
   logic [7:0]  group_in [7];
   logic [3:0]  ptgt_ff [8];
   logic [3:0]  ptgt_in [8];
   logic [3:0]  pcnt_ff, pcnt_in, pidx_ff, pidx_in;
   logic [2:0]  rtgt_ff [7];
   logic [2:0]  rtgt_in [7];
   logic [2:0]  rcnt_ff, rcnt_in, ridx_ff, ridx_in;
   logic [7:0]  rmask_ff, rmask_in;
   logic [15:0] sa_ff, sa_in, sb_ff, sb_in, len_ff, len_in;
   logic [15:0] ca_ff, ca_in, cb_ff, cb_in, done_ff, done_in;
   logic [7:0]  mask_ff, mask_in, match_ff, match_in;
   logic [7:0]  ictl_ff, ictl_in, ipulse_ff, ipulse_in, ivec_ff, ivec_in;
   logic [7:0]  stat_ff, stat_in;
   logic [1:0]  cmd_ff, cmd_in, mode_ff, mode_in;
   logic        en_ff, en_in, ien_ff, ien_in, rdy_ff, rdy_in;
   logic        mf_ff, mf_in, ef_ff, ef_in, sf_ff, sf_in;
   logic [7:0]  rd;

   always_comb begin
      logic [7:0]  v, s;
      logic [2:0]  g, ri;
      logic        rebuild;
      logic [2:0]  rc;
      v = req.data_byte;
      group_in = group_ff; ptgt_in = ptgt_ff; pcnt_in = pcnt_ff; pidx_in = pidx_ff;
      rtgt_in = rtgt_ff; rcnt_in = rcnt_ff; ridx_in = ridx_ff; rmask_in = rmask_ff;
      sa_in = sa_ff; sb_in = sb_ff; len_in = len_ff; ca_in = ca_ff; cb_in = cb_ff;
      done_in = done_ff; mask_in = mask_ff; match_in = match_ff; ictl_in = ictl_ff;
      ipulse_in = ipulse_ff; ivec_in = ivec_ff; stat_in = stat_ff; cmd_in = cmd_ff;
      mode_in = mode_ff; en_in = en_ff; ien_in = ien_ff; rdy_in = rdy_ff;
      mf_in = mf_ff; ef_in = ef_ff; sf_in = sf_ff;
      rd = 8'd0; rebuild = 1'b0; g = 3'd6; rc = 3'd0; ri = 3'd0;
      s = STATUS_BASE | {2'b00, ~ef_ff, ~mf_ff, 2'b00,
          (mode_ff != 2'd1) && (group_ff[5][3] != rdy_ff), en_ff};
      case (op_type'(req.operation))
         OP_WRITE: begin
            en_in = 1'b0;
            if (pcnt_ff == 4'd0) begin
               pcnt_in = 4'd0;
               pidx_in = 4'd0;
               if (!v[7]) begin
                  if (v[1:0] != 2'd0) g = 3'd0;
                  else if (v[2:0] == 3'd4) g = 3'd1;
                  else g = 3'd2;
               end else begin
                  if (v[1:0] == 2'd0) g = 3'd3;
                  else if (v[1:0] == 2'd1 && v[7:5] != 3'd7) g = 3'd4;
                  else if (v[2:0] == 3'd2 && !v[6]) g = 3'd5;
               end
               group_in[g] = v;
               case (g)
                  3'd0: begin
                     cmd_in = v[1:0];
                     if (v[3]) begin ptgt_in[pcnt_in[2:0]] = TGT_ADDR_A_LO; pcnt_in++; end
                     if (v[4]) begin ptgt_in[pcnt_in[2:0]] = TGT_ADDR_A_HI; pcnt_in++; end
                     if (v[5]) begin ptgt_in[pcnt_in[2:0]] = TGT_LEN_LO; pcnt_in++; end
                     if (v[6]) begin ptgt_in[pcnt_in[2:0]] = TGT_LEN_HI; pcnt_in++; end
                  end
                  3'd1, 3'd2: begin
                     if (v[6]) begin ptgt_in[0] = TGT_DISCARD; pcnt_in = 4'd1; end
                  end
                  3'd3: begin
                     if (v[3]) begin ptgt_in[pcnt_in[2:0]] = TGT_MASK; pcnt_in++; end
                     if (v[4]) begin ptgt_in[pcnt_in[2:0]] = TGT_MATCH; pcnt_in++; end
                     ien_in = v[5];
                     en_in = v[6];
                  end
                  3'd4: begin
                     mode_in = v[6:5];
                     if (v[2]) begin ptgt_in[pcnt_in[2:0]] = TGT_ADDR_B_LO; pcnt_in++; end
                     if (v[3]) begin ptgt_in[pcnt_in[2:0]] = TGT_ADDR_B_HI; pcnt_in++; end
                     if (v[4]) begin ptgt_in[pcnt_in[2:0]] = TGT_INT_CTRL; pcnt_in++; end
                  end
                  3'd6: begin
                     case (v)
                        CMD_DISABLE: en_in = 1'b0;
                        CMD_ENABLE: en_in = 1'b1;
                        CMD_CLR_FLAGS: begin mf_in = 1'b0; ef_in = 1'b0; end
                        CMD_REINIT_RD: rebuild = 1'b1;
                        CMD_INT_ON: ien_in = 1'b1;
                        CMD_INT_OFF: ien_in = 1'b0;
                        CMD_FORCE_RDY: rdy_in = group_ff[5][3];
                        CMD_RD_MASK: begin ptgt_in[0] = TGT_READ_MASK; pcnt_in = 4'd1; end
                        CMD_RD_STATUS: begin rmask_in = 8'd1; rebuild = 1'b1; end
                        CMD_RESET: begin cmd_in = 2'd0; en_in = 1'b0; ien_in = 1'b0; end
                        CMD_LOAD: begin
                           mode_in = group_ff[4][6:5];
                           ca_in = sa_ff; cb_in = sb_ff; done_in = 16'hffff;
                           ef_in = 1'b0; mf_in = 1'b0; en_in = 1'b0;
                        end
                        CMD_CONTINUE: begin
                           if (sf_ff) begin
                              sf_in = 1'b0;
                              ca_in = step_counter(ca_ff, group_ff[1]);
                              cb_in = step_counter(cb_ff, group_ff[2]);
                           end
                           done_in = 16'hffff;
                           mf_in = 1'b0; ef_in = 1'b0; en_in = 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end else begin
               case (target_type'(ptgt_ff[pidx_ff[2:0]]))
                  TGT_ADDR_A_LO: sa_in[7:0] = v;
                  TGT_ADDR_A_HI: sa_in[15:8] = v;
                  TGT_LEN_LO: len_in[7:0] = v;
                  TGT_LEN_HI: len_in[15:8] = v;
                  TGT_MASK: mask_in = v;
                  TGT_MATCH: match_in = v;
                  TGT_ADDR_B_LO: sb_in[7:0] = v;
                  TGT_ADDR_B_HI: sb_in[15:8] = v;
                  TGT_INT_CTRL: begin
                     ictl_in = v;
                     if (v[3]) begin
                        ptgt_in[3'(pidx_ff + pcnt_in)] = TGT_INT_PULSE; pcnt_in++;
                     end
                     if (v[4]) begin
                        ptgt_in[3'(pidx_ff + pcnt_in)] = TGT_INT_VECTOR; pcnt_in++;
                     end
                  end
                  TGT_INT_PULSE: ipulse_in = v;
                  TGT_INT_VECTOR: ivec_in = v;
                  TGT_READ_MASK: begin rmask_in = v; rebuild = 1'b1; end
                  default: ;
               endcase
               pidx_in = pidx_ff + 4'd1;
               pcnt_in = pcnt_in - 4'd1;
            end
         end
         OP_READ: begin
            stat_in = s;
            if (rcnt_ff == 3'd0) rd = s;
            else begin
               ri = (ridx_ff >= rcnt_ff) ? 3'd0 : ridx_ff;
               ridx_in = ri + 3'd1;
               case (rtgt_ff[ri])
                  3'd1: rd = done_ff[7:0];
                  3'd2: rd = done_ff[15:8];
                  3'd3: rd = ca_ff[7:0];
                  3'd4: rd = ca_ff[15:8];
                  3'd5: rd = cb_ff[7:0];
                  3'd6: rd = cb_ff[15:8];
                  default: rd = s;
               endcase
            end
         end
         OP_REPORT: begin
            done_in = req.report_byte_count;
            ca_in = req.report_pointer_a;
            cb_in = req.report_pointer_b;
            mf_in = req.report_match;
            ef_in = req.report_end;
            sf_in = req.report_stopped;
         end
         default: ;
      endcase
      if (rebuild) begin
         for (int b = 0; b < 7; b++) begin
            if (rmask_in[b]) begin
               rtgt_in[rc] = 3'(b);
               rc = rc + 3'd1;
            end
         end
         rcnt_in = rc;
         ridx_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         ptgt_ff <= ptgt_in;
         rtgt_ff <= rtgt_in;
      end
      if (reset) begin
         for (int i = 0; i < 7; i++) group_ff[i] <= 8'd0;
         pcnt_ff <= 4'd0; pidx_ff <= 4'd0; rcnt_ff <= 3'd0; ridx_ff <= 3'd0;
         rmask_ff <= 8'd0; sa_ff <= 16'd0; sb_ff <= 16'd0; len_ff <= 16'd0;
         ca_ff <= 16'd0; cb_ff <= 16'd0; done_ff <= 16'd0; mask_ff <= 8'd0;
         match_ff <= 8'd0; ictl_ff <= 8'd0; ipulse_ff <= 8'd0; ivec_ff <= 8'd0;
         stat_ff <= STATUS_RESET; cmd_ff <= 2'd0; mode_ff <= 2'd0; en_ff <= 1'b0;
         ien_ff <= 1'b0; rdy_ff <= 1'b1; mf_ff <= 1'b0; ef_ff <= 1'b0; sf_ff <= 1'b0;
      end else if (step) begin
         group_ff <= group_in;
         pcnt_ff <= pcnt_in; pidx_ff <= pidx_in; rcnt_ff <= rcnt_in; ridx_ff <= ridx_in;
         rmask_ff <= rmask_in; sa_ff <= sa_in; sb_ff <= sb_in; len_ff <= len_in;
         ca_ff <= ca_in; cb_ff <= cb_in; done_ff <= done_in; mask_ff <= mask_in;
         match_ff <= match_in; ictl_ff <= ictl_in; ipulse_ff <= ipulse_in;
         ivec_ff <= ivec_in; stat_ff <= stat_in; cmd_ff <= cmd_in; mode_ff <= mode_in;
         en_ff <= en_in; ien_ff <= ien_in; rdy_ff <= rdy_in; mf_ff <= mf_in;
         ef_ff <= ef_in; sf_ff <= sf_in;
      end
   end

   always_comb begin
      rsp.read_data = rd;
      rsp.transfer_enabled = en_in;
      rsp.interrupt_enabled = ien_in;
      rsp.command = cmd_in;
      rsp.mode = mode_in;
      rsp.direction_a_to_b = group_in[0][2];
      rsp.pointer_a = ca_in;
      rsp.pointer_b = cb_in;
      rsp.block_length = len_in;
      rsp.port_a_setting = group_in[1];
      rsp.port_b_setting = group_in[2];
      rsp.match_byte = match_in;
   end

endmodule

>>> rtl/dma_controller_register_port_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA controller register port
// Programming port of a DMA controller: one bus access in, one result word out.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// req       in         operation, written byte, engine progress report
// rsp       out        read byte and the programmed register view
//
// Each accepted word is decoded combinationally and its result word is held in
// the output register the next cycle; unless rsp stalls, a new word is taken
// every cycle. The output register is the only stage, so req.ready follows rsp
// being free. Reset is synchronous; afterwards the port takes words at once.
// ----------------------------------------------------------------------------
module dma_controller_register_port_unit (
   input logic   clock,
   input logic   reset,
   dcrp_req_if.sink   req,
   dcrp_rsp_if.source rsp
);
   import dcrp_pkg::*;

   logic    step;
   logic    valid_ff;
   rsp_type result;
   rsp_type data_ff;

   assign req.ready = !valid_ff || rsp.ready;
   assign step = req.valid && req.ready;

   dcrp_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req.payload),
      .rsp   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
      if (step) begin
         data_ff <= result;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.payload = data_ff;

endmodule
